### rtl/sorted_priority_queue_unit_defines.svh
// ---------------------------------------------------------------------------
// Sorted priority queue assertion macros
// Shared concurrent assertion forms, clocked on i_clk and held off in reset.
// ---------------------------------------------------------------------------
`ifndef SORTED_PRIORITY_QUEUE_UNIT_DEFINES_SVH
`define SORTED_PRIORITY_QUEUE_UNIT_DEFINES_SVH

// Implication checked at every clock edge outside reset.
`define SPQ_ASSERT_IMPL(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("spq assertion failed");

// Next-cycle implication checked outside reset.
`define SPQ_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("spq assertion failed");

`endif

### rtl/spq_pkg.sv
// ---------------------------------------------------------------------------
// Sorted priority queue package
// Shared constants, codes and the control bundle sent to every cell.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

package spq_pkg;

    localparam int DEPTH_DEF        = 16;
    localparam int PAYLOAD_BITS_DEF = 16;
    localparam int PRIO_W           = 8;
    localparam int OCC_W            = 5;

    localparam logic MODE_INSERT = 1'b0;
    localparam logic MODE_REMOVE = 1'b1;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_FULL  = 2'd1,
        ST_EMPTY = 2'd2
    } t_status;

    // Broadcast to all cells in the cycle an item is transferred.
    typedef struct packed {
        logic              ins;
        logic              rem;
        logic [PRIO_W-1:0] prio;
    } t_cell_ctrl;

endpackage

### rtl/sorted_priority_queue_unit.sv
// ---------------------------------------------------------------------------
// Sorted priority queue unit
// Bounded max-first queue with first-in first-out order among equal
// priorities, built as a chain of slot cells with a fill count.
// ---------------------------------------------------------------------------
//  Channel   Direction  Handshake            Signals
//  command   in         start && !busy       i_mode, i_priority_req, i_payload
//  result    out        o_done (one cycle)   o_out_valid, o_out_priority,
//                                            o_out_payload, o_status,
//                                            o_occupancy
//
//  One command is taken every cycle; busy stays low.
//  Its result is presented on the cycle after the transfer, with o_done high for one cycle.
//  All cells update together in that same edge.
//  Synchronous active-low reset clears the fill count and o_done; slot contents are not
//  cleared and are only read below the fill count.
//  The receiver cannot stall; o_done is not held, and the result fields change with the next command.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "sorted_priority_queue_unit_defines.svh"

module sorted_priority_queue_unit #(
    parameter int DEPTH        = spq_pkg::DEPTH_DEF,
    parameter int PAYLOAD_BITS = spq_pkg::PAYLOAD_BITS_DEF
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        start,
    output logic                        busy,
    input  logic                        i_mode,
    input  logic [spq_pkg::PRIO_W-1:0]  i_priority_req,
    input  logic [PAYLOAD_BITS-1:0]     i_payload,
    output logic                        o_done,
    output logic                        o_out_valid,
    output logic [spq_pkg::PRIO_W-1:0]  o_out_priority,
    output logic [PAYLOAD_BITS-1:0]     o_out_payload,
    output logic [1:0]                  o_status,
    output logic [spq_pkg::OCC_W-1:0]   o_occupancy
);

    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [CNT_W-1:0]           r_count, n_count;
    logic                       r_done;
    logic                       r_out_valid;
    logic [spq_pkg::PRIO_W-1:0] r_out_priority;
    logic [PAYLOAD_BITS-1:0]    r_out_payload;
    spq_pkg::t_status           r_status, n_status;

    logic                       w_full, w_empty, w_ins, w_rem;
    spq_pkg::t_cell_ctrl        w_ctrl;

    logic [spq_pkg::PRIO_W-1:0] w_prio    [DEPTH];
    logic [PAYLOAD_BITS-1:0]    w_payload [DEPTH];
    logic                       w_keep    [DEPTH];

    assign busy    = 1'b0;
    assign w_full  = (r_count == CNT_W'(DEPTH));
    assign w_empty = (r_count == '0);
    assign w_ins   = start && (i_mode == spq_pkg::MODE_INSERT) && !w_full;
    assign w_rem   = start && (i_mode == spq_pkg::MODE_REMOVE) && !w_empty;

    assign w_ctrl.ins  = w_ins;
    assign w_ctrl.rem  = w_rem;
    assign w_ctrl.prio = i_priority_req;

    genvar gi;
    generate
        for (gi = 0; gi < DEPTH; gi++) begin : g_cell
            logic                       w_prev_keep;
            logic [spq_pkg::PRIO_W-1:0] w_prev_prio, w_next_prio;
            logic [PAYLOAD_BITS-1:0]    w_prev_payload, w_next_payload;

            if (gi == 0) begin : g_head
                assign w_prev_keep    = 1'b1;
                assign w_prev_prio    = i_priority_req;
                assign w_prev_payload = i_payload;
            end else begin : g_body
                assign w_prev_keep    = w_keep[gi-1];
                assign w_prev_prio    = w_prio[gi-1];
                assign w_prev_payload = w_payload[gi-1];
            end

            if (gi == DEPTH - 1) begin : g_tail
                assign w_next_prio    = w_prio[gi];
                assign w_next_payload = w_payload[gi];
            end else begin : g_mid
                assign w_next_prio    = w_prio[gi+1];
                assign w_next_payload = w_payload[gi+1];
            end

            spq_cell #(
                .PAYLOAD_BITS (PAYLOAD_BITS)
            ) u_cell (
                .i_clk          (i_clk),
                .i_ctrl         (w_ctrl),
                .i_new_payload  (i_payload),
                .i_occupied     (CNT_W'(gi) < r_count),
                .i_prev_keep    (w_prev_keep),
                .i_prev_prio    (w_prev_prio),
                .i_prev_payload (w_prev_payload),
                .i_next_prio    (w_next_prio),
                .i_next_payload (w_next_payload),
                .o_keep         (w_keep[gi]),
                .o_prio         (w_prio[gi]),
                .o_payload      (w_payload[gi])
            );
        end
    endgenerate

    always_comb begin
        n_count  = r_count;
        n_status = spq_pkg::ST_OK;
        if (w_ins) begin
            n_count = r_count + CNT_W'(1);
        end else if (w_rem) begin
            n_count = r_count - CNT_W'(1);
        end else if (start && (i_mode == spq_pkg::MODE_INSERT)) begin
            n_status = spq_pkg::ST_FULL;
        end else if (start) begin
            n_status = spq_pkg::ST_EMPTY;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
            r_done  <= 1'b0;
        end else begin
            r_done <= start;
            if (start) begin
                r_count <= n_count;
            end
        end
        if (start) begin
            r_out_valid    <= w_rem;
            r_out_priority <= w_rem ? w_prio[0] : '0;
            r_out_payload  <= w_rem ? w_payload[0] : '0;
            r_status       <= n_status;
        end
    end

    assign o_done         = r_done;
    assign o_out_valid    = r_out_valid;
    assign o_out_priority = r_out_priority;
    assign o_out_payload  = r_out_payload;
    assign o_status       = r_status;
    assign o_occupancy    = spq_pkg::OCC_W'(r_count);

    `SPQ_ASSERT_IMPL(a_count_bound, 1'b1, r_count <= CNT_W'(DEPTH))
    `SPQ_ASSERT_IMPL(a_head_sorted, r_count >= CNT_W'(2), w_prio[0] >= w_prio[1])
    `SPQ_ASSERT_NEXT(a_refused_no_change, start && !w_ins && !w_rem, $stable(r_count))
    `SPQ_ASSERT_IMPL(a_valid_only_ok, o_done && o_out_valid, o_status == spq_pkg::ST_OK)

endmodule

### rtl/spq_cell.sv
// ---------------------------------------------------------------------------
// Sorted priority queue cell
// One slot of the queue; shifts toward the tail on insert, toward the head
// on remove, and decides locally whether to keep, load new, or take a neighbor.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module spq_cell #(
    parameter int PAYLOAD_BITS = spq_pkg::PAYLOAD_BITS_DEF
) (
    input  logic                      i_clk,
    input  spq_pkg::t_cell_ctrl       i_ctrl,
    input  logic [PAYLOAD_BITS-1:0]   i_new_payload,
    input  logic                      i_occupied,
    input  logic                      i_prev_keep,
    input  logic [spq_pkg::PRIO_W-1:0] i_prev_prio,
    input  logic [PAYLOAD_BITS-1:0]   i_prev_payload,
    input  logic [spq_pkg::PRIO_W-1:0] i_next_prio,
    input  logic [PAYLOAD_BITS-1:0]   i_next_payload,
    output logic                      o_keep,
    output logic [spq_pkg::PRIO_W-1:0] o_prio,
    output logic [PAYLOAD_BITS-1:0]   o_payload
);

    logic [spq_pkg::PRIO_W-1:0] r_prio;
    logic [PAYLOAD_BITS-1:0]    r_payload;

    // An occupied slot at or above the new priority stays where it is.
    assign o_keep    = i_occupied && (r_prio >= i_ctrl.prio);
    assign o_prio    = r_prio;
    assign o_payload = r_payload;

    always_ff @(posedge i_clk) begin
        if (i_ctrl.rem) begin
            r_prio    <= i_next_prio;
            r_payload <= i_next_payload;
        end else if (i_ctrl.ins && !o_keep) begin
            if (i_prev_keep) begin
                r_prio    <= i_ctrl.prio;
                r_payload <= i_new_payload;
            end else begin
                r_prio    <= i_prev_prio;
                r_payload <= i_prev_payload;
            end
        end
    end

endmodule

### tb/tb_top.sv
// ---------------------------------------------------------------------------
// Sorted priority queue unit testbench
// Drives inserts and removes through the start/busy command port. A local
// sorted-slot predictor computes the result of every command transfer. Each
// o_done result is checked field by field against the oldest expected
// result. A directed opening covers the empty, full and tie cases, then
// random insert and remove bursts sweep the queue between empty and full.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_top;

    localparam int QDEPTH         = spq_pkg::DEPTH_DEF;
    localparam int PAYLOAD_W      = spq_pkg::PAYLOAD_BITS_DEF;
    localparam int NUM_ITEMS      = 1850;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int MAX_REPORTS    = 10;

    typedef struct packed {
        logic                          mode;
        logic [spq_pkg::PRIO_W-1:0]    prio;
        logic [PAYLOAD_W-1:0]          data;
    } t_queue_cmd;

    typedef struct packed {
        logic                          valid;
        logic [spq_pkg::PRIO_W-1:0]    prio;
        logic [PAYLOAD_W-1:0]          data;
        spq_pkg::t_status              status;
        logic [spq_pkg::OCC_W-1:0]     occ;
    } t_queue_result;

    logic                          i_clk;
    logic                          i_rst_n;
    logic                          start;
    logic                          busy;
    logic                          i_mode;
    logic [spq_pkg::PRIO_W-1:0]    i_priority_req;
    logic [PAYLOAD_W-1:0]          i_payload;
    logic                          o_done;
    logic                          o_out_valid;
    logic [spq_pkg::PRIO_W-1:0]    o_out_priority;
    logic [PAYLOAD_W-1:0]          o_out_payload;
    logic [1:0]                    o_status;
    logic [spq_pkg::OCC_W-1:0]     o_occupancy;

    t_queue_cmd    pending_cmds[$];
    t_queue_result expected_results[$];

    // Predictor copy of the queue contents, slot 0 is the head.
    logic [spq_pkg::PRIO_W-1:0]    model_prio[QDEPTH];
    logic [PAYLOAD_W-1:0]          model_data[QDEPTH];
    int                            model_count;

    bit cmd_taken;
    int cmds_sent;
    int error_count;
    int quiet_cycles;

    sorted_priority_queue_unit i_dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .start          (start),
        .busy           (busy),
        .i_mode         (i_mode),
        .i_priority_req (i_priority_req),
        .i_payload      (i_payload),
        .o_done         (o_done),
        .o_out_valid    (o_out_valid),
        .o_out_priority (o_out_priority),
        .o_out_payload  (o_out_payload),
        .o_status       (o_status),
        .o_occupancy    (o_occupancy)
    );

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    function automatic t_queue_result apply_queue_op(t_queue_cmd cmd);
        t_queue_result res;
        int pos;
        res = '{valid: 1'b0, prio: '0, data: '0, status: spq_pkg::ST_OK, occ: '0};
        if (cmd.mode == spq_pkg::MODE_INSERT) begin
            if (model_count >= QDEPTH) begin
                res.status = spq_pkg::ST_FULL;
            end else begin
                // New entry goes behind every entry of equal or higher priority.
                pos = 0;
                while (pos < model_count && model_prio[pos] >= cmd.prio) pos++;
                for (int i = model_count; i > pos; i--) begin
                    model_prio[i] = model_prio[i-1];
                    model_data[i] = model_data[i-1];
                end
                model_prio[pos] = cmd.prio;
                model_data[pos] = cmd.data;
                model_count++;
            end
        end else if (model_count == 0) begin
            res.status = spq_pkg::ST_EMPTY;
        end else begin
            res.valid = 1'b1;
            res.prio  = model_prio[0];
            res.data  = model_data[0];
            for (int i = 1; i < model_count; i++) begin
                model_prio[i-1] = model_prio[i];
                model_data[i-1] = model_data[i];
            end
            model_count--;
        end
        res.occ = spq_pkg::OCC_W'(model_count);
        return res;
    endfunction

    task automatic add_cmd(logic mode, logic [spq_pkg::PRIO_W-1:0] prio,
                           logic [PAYLOAD_W-1:0] data);
        pending_cmds.push_back('{mode: mode, prio: prio, data: data});
    endtask

    function automatic logic [spq_pkg::PRIO_W-1:0] pick_priority();
        case ($urandom_range(3))
            0: return spq_pkg::PRIO_W'($urandom);
            1: return spq_pkg::PRIO_W'($urandom_range(3));
            2: return $urandom_range(1) ? '1 : '0;
            default: return spq_pkg::PRIO_W'($urandom_range(135, 120));
        endcase
    endfunction

    // Command driver: a command stays on the port until it is transferred.
    always @(negedge i_clk) begin : drive_cmd
        t_queue_cmd cmd;
        int idle_pct;
        if (cmds_sent < NUM_ITEMS / 3) begin
            idle_pct = 28;
        end else if (cmds_sent < 2 * NUM_ITEMS / 3) begin
            idle_pct = 55;
        end else begin
            idle_pct = 0;
        end
        if (!i_rst_n) begin
            start <= 1'b0;
        end else if (!start || cmd_taken) begin
            if (pending_cmds.size() != 0 && $urandom_range(99) >= idle_pct) begin
                cmd = pending_cmds.pop_front();
                i_mode         <= cmd.mode;
                i_priority_req <= cmd.prio;
                i_payload      <= cmd.data;
                start          <= 1'b1;
                cmds_sent      <= cmds_sent + 1;
            end else begin
                start <= 1'b0;
            end
        end
    end

    // Result monitor, command capture and watchdog.
    always @(posedge i_clk) begin : watch_queue
        t_queue_result got;
        t_queue_result want;
        bit progress;
        cmd_taken = 1'b0;
        progress  = 1'b0;
        if (i_rst_n) begin
            if (o_done) begin
                progress = 1'b1;
                got = '{valid: o_out_valid, prio: o_out_priority, data: o_out_payload,
                        status: spq_pkg::t_status'(o_status), occ: o_occupancy};
                if (expected_results.size() == 0) begin
                    error_count++;
                    if (error_count <= MAX_REPORTS)
                        $display("[%0t] result with nothing outstanding: %p", $realtime, got);
                end else begin
                    want = expected_results.pop_front();
                    if (got.valid !== want.valid || got.prio !== want.prio ||
                        got.data !== want.data || got.status !== want.status ||
                        got.occ !== want.occ) begin
                        error_count++;
                        if (error_count <= MAX_REPORTS)
                            $display("[%0t] result mismatch: expected %p, got %p",
                                     $realtime, want, got);
                    end
                end
            end
            if (start && !busy) begin
                progress  = 1'b1;
                cmd_taken = 1'b1;
                expected_results.push_back(apply_queue_op(
                    '{mode: i_mode, prio: i_priority_req, data: i_payload}));
            end
            quiet_cycles = progress ? 0 : quiet_cycles + 1;
            if (quiet_cycles >= WATCHDOG_LIMIT) begin
                $display("CHECKS FAILED");
                $finish;
            end
        end
    end

    initial begin : run_test
        int burst;
        int kind;
        i_rst_n        = 1'b0;
        start          = 1'b0;
        i_mode         = spq_pkg::MODE_INSERT;
        i_priority_req = '0;
        i_payload      = '0;
        cmds_sent      = 0;
        error_count    = 0;
        quiet_cycles   = 0;
        model_count    = 0;

        // Directed opening: empty remove, ties, extremes, fill to full,
        // refused insert, then a partial drain.
        add_cmd(spq_pkg::MODE_REMOVE, '0, '1);
        add_cmd(spq_pkg::MODE_INSERT, 8'h80, 16'h0000);
        add_cmd(spq_pkg::MODE_INSERT, 8'hFF, 16'hFFFF);
        add_cmd(spq_pkg::MODE_INSERT, 8'h00, 16'h1234);
        add_cmd(spq_pkg::MODE_INSERT, 8'h80, 16'hAAAA);
        add_cmd(spq_pkg::MODE_INSERT, 8'hFF, 16'h5555);
        add_cmd(spq_pkg::MODE_INSERT, 8'h00, 16'h0001);
        for (int i = 0; i < QDEPTH - 6; i++)
            add_cmd(spq_pkg::MODE_INSERT, spq_pkg::PRIO_W'(i * 29),
                    PAYLOAD_W'(16'h0100 + i));
        add_cmd(spq_pkg::MODE_INSERT, 8'hFF, 16'hFFFF);
        for (int i = 0; i < 6; i++)
            add_cmd(spq_pkg::MODE_REMOVE, spq_pkg::PRIO_W'($urandom),
                    PAYLOAD_W'($urandom));

        // Random bursts walk the occupancy between empty and full.
        while (pending_cmds.size() < NUM_ITEMS) begin
            kind  = $urandom_range(99);
            burst = $urandom_range(20, 1);
            for (int i = 0; i < burst; i++) begin
                if (kind < 45)
                    add_cmd(spq_pkg::MODE_INSERT, pick_priority(), PAYLOAD_W'($urandom));
                else if (kind < 90)
                    add_cmd(spq_pkg::MODE_REMOVE, spq_pkg::PRIO_W'($urandom),
                            PAYLOAD_W'($urandom));
                else
                    add_cmd(1'($urandom_range(1)), pick_priority(), PAYLOAD_W'($urandom));
            end
        end

        repeat (9) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        while (pending_cmds.size() != 0 || start) @(negedge i_clk);
        while (expected_results.size() != 0) @(negedge i_clk);
        repeat (4) @(negedge i_clk);

        if (error_count == 0 && expected_results.size() == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule
